// File: sv/plg_pkg.sv
package plg_pkg;

	// Sizing
	localparam int LEVELS      = 8;
	localparam int STACK_DEPTH = 16;
	localparam int ID_BITS     = 6;

	localparam int LVL_W   = 3;
	localparam int KIND_W  = 3;
	localparam int CNT_W   = 8;
	localparam int LIDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int FIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = LIDX_W + FIDX_W;
	localparam int RAM_DEPTH = 1 << ADDR_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Operation codes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_FINISH  = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WOKEN    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd4;
	localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd5;

	// Microcode: datapath actions
	localparam int ACT_W = 3;
	localparam logic [ACT_W-1:0] ACT_NOP    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_FETCH  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DECODE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SCAN   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_POP    = 3'd4;
	localparam logic [ACT_W-1:0] ACT_WAKE   = 3'd5;

	// Microcode: jump conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
	localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
	localparam logic [COND_W-1:0] C_NO_INPUT  = 3'd2;
	localparam logic [COND_W-1:0] C_OUT_FULL  = 3'd3;
	localparam logic [COND_W-1:0] C_OUT_STALL = 3'd4;
	localparam logic [COND_W-1:0] C_SCAN_MISS = 3'd5;
	localparam logic [COND_W-1:0] C_MORE      = 3'd6;

	// Microcode: step addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_FETCH  = 4'd0;
	localparam logic [STEP_W-1:0] S_DECODE = 4'd1;
	localparam logic [STEP_W-1:0] S_CHECK  = 4'd2;
	localparam logic [STEP_W-1:0] S_SCAN   = 4'd3;
	localparam logic [STEP_W-1:0] S_JOIN   = 4'd4;
	localparam logic [STEP_W-1:0] S_POP    = 4'd5;
	localparam logic [STEP_W-1:0] S_WAKE   = 4'd6;
	localparam logic [STEP_W-1:0] S_EMIT   = 4'd7;
	localparam logic [STEP_W-1:0] S_NEXT   = 4'd8;
	localparam logic [STEP_W-1:0] S_RET    = 4'd9;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic no_input;
		logic out_full;
		logic out_stall;
		logic scan_miss;
		logic more;
	} stat_t;

	// Control store
	function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] addr);
		ctrl_t w;
		unique case (addr)
			S_FETCH:  w = '{act: ACT_FETCH,  cond: C_NO_INPUT,  target: S_FETCH};
			S_DECODE: w = '{act: ACT_DECODE, cond: C_NEVER,     target: S_FETCH};
			S_CHECK:  w = '{act: ACT_NOP,    cond: C_OUT_FULL,  target: S_EMIT};
			S_SCAN:   w = '{act: ACT_SCAN,   cond: C_SCAN_MISS, target: S_SCAN};
			S_JOIN:   w = '{act: ACT_NOP,    cond: C_OUT_FULL,  target: S_EMIT};
			S_POP:    w = '{act: ACT_POP,    cond: C_NEVER,     target: S_FETCH};
			S_WAKE:   w = '{act: ACT_WAKE,   cond: C_NEVER,     target: S_FETCH};
			S_EMIT:   w = '{act: ACT_NOP,    cond: C_OUT_STALL, target: S_EMIT};
			S_NEXT:   w = '{act: ACT_NOP,    cond: C_MORE,      target: S_POP};
			S_RET:    w = '{act: ACT_NOP,    cond: C_ALWAYS,    target: S_FETCH};
			default:  w = '{act: ACT_NOP,    cond: C_ALWAYS,    target: S_FETCH};
		endcase
		return w;
	endfunction

endpackage

// File: sv/priority_level_gate.sv
// Priority level gate: admits requesters only at the current top level.
//
// Channels: request side req_valid/req_ready carries operation, priority_req
// and requester_id; result side res_valid/res_ready carries kind, agent_id,
// level and last. A transfer happens on a rising edge with valid and ready
// both high. One request yields exactly one result with last set; a finish
// yields one released/ignored result, or one woken result per waiter popped
// from the chosen level's stack, newest first, last set on the final one.
//
// Timing: a small microcoded sequencer walks each item through a control
// store, one step per cycle, and takes one item at a time. A request, an
// ignored finish or a finish that leaves the count above zero goes through
// the fetch, decode, check, emit, next and return steps; its result is
// registered in decode. A finish that drops the count to zero scans one
// level per cycle from the top, down to the first non-empty stack or level
// 0; with all stacks empty the released result is registered in the last
// scan step. Otherwise each woken agent then passes the pop, wake, emit and
// next steps: the stack entry is read from the id RAM through its registered
// read port.
//
// Reset (arst_n low): level 0, active count 0, all stacks empty; the id RAM
// holds no reset value and only entries below a stack's fill are read.
// Receiver stall: the result register holds its value while res_ready is
// low and req_ready stays low until every result of the item has gone.
module priority_level_gate (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         operation,
	input  logic [plg_pkg::LVL_W-1:0]    priority_req,
	input  logic [plg_pkg::ID_BITS-1:0]  requester_id,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [plg_pkg::KIND_W-1:0]   kind,
	output logic [plg_pkg::ID_BITS-1:0]  agent_id,
	output logic [plg_pkg::LVL_W-1:0]    level,
	output logic                         last
);
	import plg_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// sequencer: step counter plus control store
	plg_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	// datapath: level/count/fill registers, id RAM, result register
	plg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.operation   (operation),
		.priority_req(priority_req),
		.requester_id(requester_id),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.kind        (kind),
		.agent_id    (agent_id),
		.level       (level),
		.last        (last)
	);

endmodule

// File: sv/plg_ram.sv
module plg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/plg_seq.sv
module plg_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  plg_pkg::stat_t stat,
	output plg_pkg::ctrl_t ctrl
);
	import plg_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              jump;

	assign ctrl = ucode_rom(step_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_INPUT:  jump = stat.no_input;
			C_OUT_FULL:  jump = stat.out_full;
			C_OUT_STALL: jump = stat.out_stall;
			C_SCAN_MISS: jump = stat.scan_miss;
			C_MORE:      jump = stat.more;
			default:     jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_FETCH;
		end else if (jump) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// File: sv/plg_dp.sv
module plg_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  plg_pkg::ctrl_t               ctrl,
	output plg_pkg::stat_t               stat,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         operation,
	input  logic [plg_pkg::LVL_W-1:0]    priority_req,
	input  logic [plg_pkg::ID_BITS-1:0]  requester_id,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [plg_pkg::KIND_W-1:0]   kind,
	output logic [plg_pkg::ID_BITS-1:0]  agent_id,
	output logic [plg_pkg::LVL_W-1:0]    level,
	output logic                         last
);
	import plg_pkg::*;

	// captured item
	logic               op_q;
	logic [LVL_W-1:0]   prio_q;
	logic [ID_BITS-1:0] id_q;

	// gate state
	logic [LVL_W-1:0]   cur_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FILL_W-1:0]  fill_q [LEVELS];
	logic [LIDX_W-1:0]  scan_q;
	logic               top_zero_q;

	// result register
	logic               res_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [ID_BITS-1:0] agent_q;
	logic [LVL_W-1:0]   level_q;
	logic               last_q;

	logic [LVL_W-1:0]   prio_clamp;
	logic [LIDX_W-1:0]  sel_idx;
	logic [FILL_W-1:0]  fill_sel;
	logic [FILL_W-1:0]  fill_top;
	logic               room;
	logic               is_req;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   cnt_dec;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ID_BITS-1:0] ram_rdata;

	assign prio_clamp = (int'(priority_req) >= LEVELS) ? LVL_W'(LEVELS - 1) : priority_req;

	assign sel_idx  = (ctrl.act == ACT_DECODE) ? LIDX_W'(prio_q) : scan_q;
	assign fill_sel = fill_q[sel_idx];
	assign fill_top = fill_sel - 1'b1;
	assign room     = (fill_sel != FILL_W'(STACK_DEPTH));
	assign is_req   = (op_q == OP_REQUEST);
	assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign cnt_dec  = (cnt_q == '0) ? cnt_q : cnt_q - 1'b1;

	assign ram_we    = (ctrl.act == ACT_DECODE) && is_req && (prio_q < cur_q) && room;
	assign ram_waddr = {LIDX_W'(prio_q), FIDX_W'(fill_sel)};
	assign ram_raddr = {scan_q, FIDX_W'(fill_top)};

	plg_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(id_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready = (ctrl.act == ACT_FETCH);

	assign stat.no_input  = !req_valid;
	assign stat.out_full  = res_valid_q;
	assign stat.out_stall = res_valid_q && !res_ready;
	assign stat.scan_miss = (fill_sel == '0) && (scan_q != '0);
	assign stat.more      = !last_q;

	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign agent_id  = agent_q;
	assign level     = level_q;
	assign last      = last_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			cnt_q       <= '0;
			scan_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (ctrl.act)
				ACT_DECODE: begin
					if (is_req) begin
						res_valid_q <= 1'b1;
						if (prio_q == cur_q) begin
							cnt_q <= cnt_inc;
						end else if (prio_q > cur_q) begin
							cur_q <= prio_q;
							cnt_q <= CNT_W'(1);
						end else if (room) begin
							fill_q[sel_idx] <= fill_sel + 1'b1;
						end
					end else if (prio_q < cur_q) begin
						res_valid_q <= 1'b1;
					end else begin
						cnt_q <= cnt_dec;
						if (cnt_dec != '0) begin
							res_valid_q <= 1'b1;
						end else begin
							scan_q <= LIDX_W'(LEVELS - 1);
						end
					end
				end
				ACT_SCAN: begin
					if (fill_sel != '0) begin
						cur_q <= LVL_W'(scan_q);
						cnt_q <= '0;
					end else if (scan_q == '0) begin
						cur_q       <= '0;
						cnt_q       <= '0;
						res_valid_q <= 1'b1;
					end else begin
						scan_q <= scan_q - 1'b1;
					end
				end
				ACT_POP: begin
					fill_q[scan_q] <= fill_top;
				end
				ACT_WAKE: begin
					cnt_q       <= cnt_inc;
					res_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			ACT_FETCH: begin
				if (req_valid) begin
					op_q   <= operation;
					prio_q <= prio_clamp;
					id_q   <= requester_id;
				end
			end
			ACT_DECODE: begin
				last_q <= 1'b1;
				if (is_req) begin
					agent_q <= id_q;
					level_q <= (prio_q > cur_q) ? prio_q : cur_q;
					if (prio_q >= cur_q) begin
						kind_q <= KIND_GRANTED;
					end else if (room) begin
						kind_q <= KIND_QUEUED;
					end else begin
						kind_q <= KIND_REJECTED;
					end
				end else begin
					agent_q <= '0;
					level_q <= cur_q;
					kind_q  <= (prio_q < cur_q) ? KIND_IGNORED : KIND_RELEASED;
				end
			end
			ACT_SCAN: begin
				kind_q  <= KIND_RELEASED;
				agent_q <= '0;
				level_q <= '0;
				last_q  <= 1'b1;
			end
			ACT_POP: begin
				top_zero_q <= (fill_top == '0);
			end
			ACT_WAKE: begin
				kind_q  <= KIND_WOKEN;
				agent_q <= ram_rdata;
				level_q <= cur_q;
				last_q  <= top_zero_q;
			end
			default: ;
		endcase
	end

endmodule

// File: sv/plg_checker.sv
module plg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [plg_pkg::KIND_W-1:0]   kind,
	input logic [plg_pkg::ID_BITS-1:0]  agent_id,
	input logic                         last
);
	import plg_pkg::*;

	// held result must not change under stall
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(agent_id)
			&& $stable(last))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("back-to-back request transfer");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("request taken while a result is pending");

	// requests give a single result
	a_req_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_GRANTED || kind == KIND_QUEUED
			|| kind == KIND_REJECTED) |-> last)
		else $error("request result without last");

	a_noid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_RELEASED || kind == KIND_IGNORED)
			|-> agent_id == '0 && last)
		else $error("released or ignored result carries an id");

endmodule

bind priority_level_gate plg_checker u_chk (.*);

// File: test/priority_level_gate_tb.sv
`timescale 1ns / 100ps

// Testbench for priority_level_gate.
// A scoreboard model of the gate (current level, active count, one LIFO of
// waiting ids per level) predicts the results of every request transfer.
// The checker compares each result transfer, field by field, against the
// oldest prediction.
// Directed tests come first. Then a short count up/down run and a random mix
// of requests and finishes, with bursts of idling on both channels.
module priority_level_gate_tb;
	import plg_pkg::*;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [ID_BITS-1:0] agent;
		logic [LVL_W-1:0]   lvl;
		logic               last_flag;
	} gate_result_t;

	logic clk = 1'b0;
	logic arst_n;

	// request channel
	logic               req_valid;
	logic               req_ready;
	logic               operation;
	logic [LVL_W-1:0]   priority_req;
	logic [ID_BITS-1:0] requester_id;

	// result channel
	logic               res_valid;
	logic               res_ready;
	logic [KIND_W-1:0]  kind;
	logic [ID_BITS-1:0] agent_id;
	logic [LVL_W-1:0]   level;
	logic               last;

	// scoreboard copy of the gate state
	logic [LVL_W-1:0]   lvl_now;
	logic [CNT_W-1:0]   count_now;
	logic [ID_BITS-1:0] stack_ids [LEVELS][STACK_DEPTH];
	int unsigned        stack_cnt [LEVELS];

	gate_result_t pending_results[$];

	int errors       = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int wakes_seen   = 0;
	int rx_hold      = 0;
	bit idling_on    = 1'b1;

	priority_level_gate uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.operation    (operation),
		.priority_req (priority_req),
		.requester_id (requester_id),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.kind         (kind),
		.agent_id     (agent_id),
		.level        (level),
		.last         (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// Scoreboard model
	// ------------------------------------------------------------------
	function automatic void add_result(logic [KIND_W-1:0] k, logic [ID_BITS-1:0] a,
			logic [LVL_W-1:0] l, logic lst);
		gate_result_t r;
		r.kind      = k;
		r.agent     = a;
		r.lvl       = l;
		r.last_flag = lst;
		pending_results.push_back(r);
	endfunction

	// Works out what one accepted transfer does to the gate and queues
	// the results it should produce.
	function automatic void predict_outcome(logic op, logic [LVL_W-1:0] prio,
			logic [ID_BITS-1:0] id);
		int unsigned p;
		int          lv;
		p = prio;
		// out-of-range levels fold onto the top level
		if (p >= LEVELS)
			p = LEVELS - 1;

		if (op == OP_REQUEST) begin
			if (p == lvl_now) begin
				if (count_now != COUNT_MAX)
					count_now++;
				add_result(KIND_GRANTED, id, lvl_now, 1'b1);
			end else if (p > lvl_now) begin
				lvl_now   = LVL_W'(p);
				count_now = CNT_W'(1);
				add_result(KIND_GRANTED, id, lvl_now, 1'b1);
			end else if (stack_cnt[p] < STACK_DEPTH) begin
				stack_ids[p][stack_cnt[p]] = id;
				stack_cnt[p]++;
				add_result(KIND_QUEUED, id, lvl_now, 1'b1);
			end else begin
				add_result(KIND_REJECTED, id, lvl_now, 1'b1);
			end
			return;
		end

		// finish below the current level: no effect
		if (p < lvl_now) begin
			add_result(KIND_IGNORED, '0, lvl_now, 1'b1);
			return;
		end

		if (count_now != 0)
			count_now--;
		if (count_now != 0) begin
			add_result(KIND_RELEASED, '0, lvl_now, 1'b1);
			return;
		end

		// count hit zero: top-down scan, level 0 included
		lv = LEVELS - 1;
		while (lv >= 0 && stack_cnt[lv] == 0)
			lv--;
		if (lv < 0) begin
			lvl_now   = '0;
			count_now = '0;
			add_result(KIND_RELEASED, '0, lvl_now, 1'b1);
			return;
		end

		// wake the whole stack, newest first
		lvl_now   = LVL_W'(lv);
		count_now = '0;
		while (stack_cnt[lv] != 0) begin
			stack_cnt[lv]--;
			if (count_now != COUNT_MAX)
				count_now++;
			add_result(KIND_WOKEN, stack_ids[lv][stack_cnt[lv]], lvl_now,
				stack_cnt[lv] == 0);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls and the checker
	// ------------------------------------------------------------------
	// Random stall bursts on res_ready while idling is on.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold   <= rx_hold - 1;
			res_ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			rx_hold   <= $urandom_range(0, 14);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		gate_result_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (kind == KIND_WOKEN)
				wakes_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d agent_id %0d level %0d last %0b",
					kind, agent_id, level, last);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					errors++;
				end
				if (agent_id !== want.agent) begin
					$error("agent_id: expected %0d, got %0d", want.agent, agent_id);
					errors++;
				end
				if (level !== want.lvl) begin
					$error("level: expected %0d, got %0d", want.lvl, level);
					errors++;
				end
				if (last !== want.last_flag) begin
					$error("last: expected %0b, got %0b", want.last_flag, last);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Drops valid at the next falling edge, then idles.
	task automatic sender_gap(input int n);
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Sender holds off until every predicted result has come back.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// One request-side transfer. Returns at the rising edge that took it,
	// with valid still high; the next call or a gap lowers or reloads it.
	task automatic send_item(input logic op, input logic [LVL_W-1:0] prio,
			input logic [ID_BITS-1:0] id);
		if (idling_on && $urandom_range(0, 3) == 0)
			sender_gap($urandom_range(1, 15));
		@(negedge clk);
		req_valid    <= 1'b1;
		operation    <= op;
		priority_req <= prio;
		requester_id <= id;
		do
			@(posedge clk);
		while (!req_ready);
		predict_outcome(op, prio, id);
		items_sent++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Finishes straight after reset: count already zero, every stack empty.
	task automatic test_finish_from_reset();
		send_item(OP_FINISH, 3'd0, 6'd0);
		send_item(OP_FINISH, 3'd3, 6'd63);
	endtask

	// Grant at the current level, raise to the top, ignored and released finishes.
	task automatic test_grant_and_raise();
		send_item(OP_REQUEST, 3'd0, 6'd0);
		send_item(OP_REQUEST, 3'd7, 6'd63);
		send_item(OP_REQUEST, 3'd7, 6'd42);
		send_item(OP_FINISH, 3'd0, 6'd17);
		send_item(OP_FINISH, 3'd6, 6'd0);
		send_item(OP_FINISH, 3'd7, 6'd0);
	endtask

	// Fill one stack, overflow it, then wake the full stack in one finish.
	task automatic test_stack_fill_and_wake();
		for (int i = 0; i < STACK_DEPTH; i++)
			send_item(OP_REQUEST, 3'd5, (i == STACK_DEPTH - 1) ? 6'd63 : ID_BITS'(i * 5));
		send_item(OP_REQUEST, 3'd5, 6'd21);      // stack full: rejected
		send_item(OP_REQUEST, 3'd2, 6'd33);      // stays queued for later
		wait_drained();
		send_item(OP_FINISH, 3'd7, 6'd0);        // count to zero, sixteen woken
	endtask

	// Raise the active count a little, then finish it all the way down.
	task automatic test_count_up_down();
		for (int i = 0; i < 4; i++)
			send_item(OP_REQUEST, lvl_now, ID_BITS'($urandom_range(0, 63)));
		while (lvl_now != 0 || count_now != 0)
			send_item(OP_FINISH, lvl_now, ID_BITS'($urandom_range(0, 63)));
	endtask

	// Mostly well-formed traffic: requests at any level, finishes at or
	// above the current level; some stray finishes below it.
	task automatic test_random_traffic();
		int unsigned choice;
		for (int i = 0; i < 80; i++) begin
			if (i == 40)
				wait_drained();
			if (i == 60)
				idling_on = 1'b0;        // no idling in the closing stretch
			choice = $urandom_range(0, 99);
			if (choice < 40)
				send_item(OP_REQUEST, LVL_W'($urandom_range(0, 7)),
					ID_BITS'($urandom_range(0, 63)));
			else if (choice < 55)
				send_item(OP_REQUEST, lvl_now, ID_BITS'($urandom_range(0, 63)));
			else if (choice < 90)
				send_item(OP_FINISH, LVL_W'($urandom_range(lvl_now, LEVELS - 1)),
					ID_BITS'($urandom_range(0, 63)));
			else
				send_item(OP_FINISH, LVL_W'($urandom_range(0, 7)),
					ID_BITS'($urandom_range(0, 63)));
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		operation    = OP_REQUEST;
		priority_req = '0;
		requester_id = '0;
		res_ready    = 1'b0;
		lvl_now      = '0;
		count_now    = '0;
		foreach (stack_cnt[l])
			stack_cnt[l] = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_finish_from_reset();
		test_grant_and_raise();
		test_stack_fill_and_wake();
		test_count_up_down();
		test_random_traffic();

		// let stragglers show up as unexpected results
		wait_drained();
		repeat (100) @(posedge clk);

		$display("Covered %0d request-side transfers and %0d results, %0d of them wake-ups,",
			items_sent, results_seen, wakes_seen);
		$display("including stack overflow, a full-stack wake and empty-gate finishes.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
sv/plg_pkg.sv
sv/plg_ram.sv
sv/plg_seq.sv
sv/plg_dp.sv
sv/priority_level_gate.sv
sv/plg_checker.sv
test/priority_level_gate_tb.sv
